### hdl/psfp_pkg.sv
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared types and constants of the particle sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

  // Number of data words in one frame.
  localparam int DATA_WORDS   = 13;
  // Value the length field must carry.
  localparam int FRAME_LENGTH = 28;

  localparam int WORD_ADDR_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int BYTE_POS_W  = WORD_ADDR_W + 1;
  localparam int CFG_IDX_W   = 1;

  typedef logic [7:0]             byte_t;
  typedef logic [15:0]            word_t;
  typedef logic [3:0]             index_t;
  typedef logic [WORD_ADDR_W-1:0] word_addr_t;
  typedef logic [BYTE_POS_W-1:0]  byte_pos_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_START_FIRST  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_START_SECOND = cfg_idx_t'(1);

  localparam byte_t START_FIRST_RESET  = 8'd66;
  localparam byte_t START_SECOND_RESET = 8'd77;

  // Event handed from the parser to the result drain.
  typedef struct packed {
    logic    start;       // good frame complete, read out all words
    logic    err;         // failed check, emit one error result
    status_t err_status;
  } psfp_evt_t;

endpackage

### hdl/psfp_rx_if.sv
// ----------------------------------------------------------------------------
// psfp_rx_if
// Byte channel into the frame parser.
// ----------------------------------------------------------------------------
interface psfp_rx_if import psfp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/psfp_result_if.sv
// ----------------------------------------------------------------------------
// psfp_result_if
// Result channel out of the frame parser.
// ----------------------------------------------------------------------------
interface psfp_result_if import psfp_pkg::*; ();
  logic    valid;
  logic    ready;
  index_t  word_index;
  word_t   word_value;
  status_t status;
  logic    last;

  modport source (output valid, output word_index, output word_value, output status,
                  output last, input ready);
  modport sink   (input valid, input word_index, input word_value, input status,
                  input last, output ready);
endinterface

### hdl/particle_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Byte-stream frame parser for a particle sensor link.
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel, one per transfer, and results leave
// on the result channel. Bytes are dropped until the first start byte; then
// the second start byte, a length field of 28, the data words and a checksum
// over every preceding frame byte are checked. The parser handles each byte
// as it is taken, so rx accepts a byte in every cycle while no results are
// pending. After the second checksum byte of a good frame the data words are
// read out of the word RAM, one transfer per cycle when the receiver keeps
// up; the first word passes the read address, RAM read and result registers.
// A failed check gives a single error result, which passes the error pending
// and result registers. While a readout or an error result is queued, rx is
// held off; the result register still lets a byte through while the final
// result waits to be taken, and a stall on the result channel holds the
// current result and the readout. The user must set the start bytes through
// the configuration port only while idle; the block does not enforce this.
// Reset (synchronous, active high) returns to hunting and restores the start
// bytes to 0x42 and 0x4D; the word RAM is not cleared, since every entry is
// written before a good frame reads it.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser import psfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data,
  psfp_rx_if.sink       rx,
  psfp_result_if.source result
);

  psfp_evt_t  evt;
  logic       busy;
  logic       take;
  logic       ram_we, ram_re;
  word_addr_t ram_waddr, ram_raddr;
  word_t      ram_wdata, ram_rdata;

  // Input is interlocked against the readout, so a new frame never writes
  // the word RAM while the previous one is still being read.
  assign rx.ready = !busy;
  assign take     = rx.valid && rx.ready;

  psfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (rx.rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .evt       (evt)
  );

  psfp_word_ram #(
    .DEPTH (DATA_WORDS),
    .WIDTH ($bits(word_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psfp_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .busy      (busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

endmodule

### hdl/psfp_word_ram.sv
// ----------------------------------------------------------------------------
// psfp_word_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psfp_word_ram #(
  parameter int DEPTH  = 13,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/psfp_parser.sv
// ----------------------------------------------------------------------------
// psfp_parser
// Frame state machine: start bytes, length, data words and checksum.
// ----------------------------------------------------------------------------
module psfp_parser import psfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  cfg_idx_t   cfg_index,
  input  byte_t      cfg_data,
  input  logic       take,
  input  byte_t      rx_byte,
  output logic       ram_we,
  output word_addr_t ram_waddr,
  output word_t      ram_wdata,
  output psfp_evt_t  evt
);

  typedef enum logic [2:0] {
    HUNT   = 3'd0,
    SECOND = 3'd1,
    LEN_HI = 3'd2,
    LEN_LO = 3'd3,
    DATA   = 3'd4,
    SUM_HI = 3'd5,
    SUM_LO = 3'd6
  } phase_t;

  phase_t    phase, phase_next;
  byte_pos_t byte_pos, byte_pos_next;
  word_t     running_sum, running_sum_next;
  byte_t     high_hold, high_hold_next;
  byte_t     start_first, start_second;
  word_t     pair;

  assign pair      = {high_hold, rx_byte};
  assign ram_waddr = byte_pos[BYTE_POS_W-1:1];
  assign ram_wdata = pair;

  always_comb begin
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    running_sum_next = running_sum;
    high_hold_next   = high_hold;
    ram_we           = 1'b0;
    evt              = '0;
    evt.err_status   = ST_OK;
    if (take) begin
      unique case (phase)
        SECOND: begin
          if (rx_byte != start_second) begin
            evt.err        = 1'b1;
            evt.err_status = ST_BAD_START;
            phase_next     = HUNT;
          end else begin
            running_sum_next = running_sum + word_t'(rx_byte);
            phase_next       = LEN_HI;
          end
        end
        LEN_HI: begin
          high_hold_next   = rx_byte;
          running_sum_next = running_sum + word_t'(rx_byte);
          phase_next       = LEN_LO;
        end
        LEN_LO: begin
          running_sum_next = running_sum + word_t'(rx_byte);
          if (pair != word_t'(FRAME_LENGTH)) begin
            evt.err        = 1'b1;
            evt.err_status = ST_BAD_LEN;
            phase_next     = HUNT;
          end else begin
            byte_pos_next = '0;
            phase_next    = DATA;
          end
        end
        DATA: begin
          running_sum_next = running_sum + word_t'(rx_byte);
          if (!byte_pos[0]) begin
            high_hold_next = rx_byte;
          end else begin
            ram_we = 1'b1;
          end
          byte_pos_next = byte_pos + byte_pos_t'(1);
          if (byte_pos == byte_pos_t'(2 * DATA_WORDS - 1)) begin
            phase_next = SUM_HI;
          end
        end
        SUM_HI: begin
          high_hold_next = rx_byte;
          phase_next     = SUM_LO;
        end
        SUM_LO: begin
          phase_next = HUNT;
          if (pair != running_sum) begin
            evt.err        = 1'b1;
            evt.err_status = ST_BAD_SUM;
          end else begin
            evt.start = 1'b1;
          end
        end
        default: begin
          phase_next = HUNT;
          if (rx_byte == start_first) begin
            running_sum_next = word_t'(rx_byte);
            phase_next       = SECOND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= HUNT;
      byte_pos     <= '0;
      running_sum  <= '0;
      high_hold    <= '0;
      start_first  <= START_FIRST_RESET;
      start_second <= START_SECOND_RESET;
    end else begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      running_sum <= running_sum_next;
      high_hold   <= high_hold_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_START_FIRST:  start_first  <= cfg_data;
          CFG_START_SECOND: start_second <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_evt_excl: assert property (@(posedge clk) disable iff (rst)
    !(evt.start && evt.err))
    else $error("frame start and error raised together");
  a_write_in_data: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (phase == DATA) && byte_pos[0])
    else $error("word store written outside a data low byte");
  a_start_after_sum: assert property (@(posedge clk) disable iff (rst)
    evt.start |=> phase == HUNT)
    else $error("parser did not return to hunting after a good frame");
`endif

endmodule

### hdl/psfp_drain.sv
// ----------------------------------------------------------------------------
// psfp_drain
// Reads the stored words out to the result channel and emits error results.
// ----------------------------------------------------------------------------
module psfp_drain import psfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  psfp_evt_t  evt,
  output logic       busy,
  output logic       ram_re,
  output word_addr_t ram_raddr,
  input  word_t      ram_rdata,
  psfp_result_if.source result
);

  logic       rd_active;
  word_addr_t rd_addr;
  logic       q_valid;
  word_addr_t q_idx;
  logic       err_pend;
  status_t    err_status;
  logic       out_free, load_q, load_err;

  assign out_free  = !result.valid || result.ready;
  assign load_q    = q_valid && out_free;
  assign load_err  = err_pend && !q_valid && out_free;
  assign ram_re    = rd_active && (!q_valid || load_q);
  assign ram_raddr = rd_addr;
  assign busy      = rd_active || q_valid || err_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active    <= 1'b0;
      rd_addr      <= '0;
      q_valid      <= 1'b0;
      err_pend     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (evt.start) begin
        rd_active <= 1'b1;
        rd_addr   <= '0;
      end else if (ram_re) begin
        if (rd_addr == word_addr_t'(DATA_WORDS - 1)) begin
          rd_active <= 1'b0;
        end else begin
          rd_addr <= rd_addr + word_addr_t'(1);
        end
      end
      if (ram_re) begin
        q_valid <= 1'b1;
        q_idx   <= rd_addr;
      end else if (load_q) begin
        q_valid <= 1'b0;
      end
      if (evt.err) begin
        err_pend   <= 1'b1;
        err_status <= evt.err_status;
      end else if (load_err) begin
        err_pend <= 1'b0;
      end
      if (load_q) begin
        result.valid      <= 1'b1;
        result.word_index <= index_t'(q_idx);
        result.word_value <= ram_rdata;
        result.status     <= ST_OK;
        result.last       <= (q_idx == word_addr_t'(DATA_WORDS - 1));
      end else if (load_err) begin
        result.valid      <= 1'b1;
        result.word_index <= '0;
        result.word_value <= '0;
        result.status     <= err_status;
        result.last       <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_evt_when_idle: assert property (@(posedge clk) disable iff (rst)
    (evt.start || evt.err) |-> !busy)
    else $error("parser event while the drain is busy");
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    !(err_pend && (rd_active || q_valid)))
    else $error("error pending during a frame readout");
  a_final_read: assert property (@(posedge clk) disable iff (rst)
    (ram_re && rd_addr == word_addr_t'(DATA_WORDS - 1) && !evt.start) |=> !rd_active)
    else $error("readout continued past the last word");
`endif

endmodule
